@@ rtl/core/rv32_pkg.sv @@
// Package for the RV32I executor: widths, codes and state enum.
package rv32_pkg;

  localparam int MemAddrBits = 16;
  localparam int MemWords    = 1 << (MemAddrBits - 2);
  localparam int WordBits    = MemAddrBits - 2;

  // Request actions
  localparam logic [1:0] ACT_WRITE_BYTE = 2'd0;
  localparam logic [1:0] ACT_EXECUTE    = 2'd1;
  localparam logic [1:0] ACT_READ_REG   = 2'd2;

  // Syscall kinds reported with each result
  localparam logic [2:0] SYS_NONE   = 3'd0;
  localparam logic [2:0] SYS_PRINT  = 3'd1;
  localparam logic [2:0] SYS_EXIT   = 3'd2;
  localparam logic [2:0] SYS_READ   = 3'd3;
  localparam logic [2:0] SYS_UNIMPL = 3'd4;
  localparam logic [2:0] SYS_BREAK  = 3'd5;

  // Opcodes
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [31:0] INS_ECALL  = 32'h0000_0073;
  localparam logic [31:0] INS_EBREAK = 32'h0010_0073;
  localparam logic [6:0]  F7_ALT     = 7'h20;

  // ecall argument registers and service numbers
  localparam logic [4:0]  REG_ARG0  = 5'd10;
  localparam logic [4:0]  REG_SVC   = 5'd17;
  localparam logic [31:0] SVC_PRINT = 32'd1;
  localparam logic [31:0] SVC_READ  = 32'd5;
  localparam logic [31:0] SVC_EXIT  = 32'd10;

  typedef enum logic [3:0] {
    ST_CLEAR,   // sweep memory to zero after reset
    ST_IDLE,
    ST_FETCH,   // instruction word read issued
    ST_DECODE,  // instruction word and rs1 available
    ST_OPS,     // rs2 available, execute
    ST_MEM0,    // data word 0 read returned
    ST_MEM1,    // instruction word 1 read returned
    ST_REGOUT,  // register file read for the result
    ST_RESULT
  } state_t;

endpackage

@@ rtl/core/rv32i_instruction_executor.sv @@
// RV32I executor top level: word memory, register file, sequencer, result stage.
// Path to out_tvalid: ST_REGOUT and ST_RESULT for a byte write, a register read or a halted
//   execute; an execute first passes ST_FETCH, ST_MEM1 and ST_DECODE, then ST_OPS unless the
//   word is zero, and loads and stores add ST_MEM0. One request at a time: the next is taken
//   after the result loads, and later while the result is stalled.
// Reset: rst_n synchronous; clears pc, count and halt flag, then sweeps the 16K-word
//   memory and the register file to zero before taking requests.
module rv32i_instruction_executor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // action[1:0], byte_address[17:2], byte_data[25:18], reg_index[30:26],
  // console_value[62:31], zero pad [63]
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // halted[0], pc_value[32:1], cycle_value[64:33], reg_value[96:65],
  // syscall_kind[99:97], syscall_value[131:100], zero pad [135:132]
  output logic [135:0] out_tdata
);

  localparam int WB = rv32_pkg::WordBits;

  rv32_pkg::state_t state_r, state_nxt;

  logic [31:0] pc_r, cnt_r;
  logic        halt_r;
  logic [WB-1:0] clr_r;

  // latched request
  logic [1:0]  act_r;
  logic [4:0]  ridx_r;
  logic [31:0] cons_r;

  logic [31:0] ins_r, a_r;
  logic [31:0] w0_r;
  logic [31:0] ea_r;
  logic [2:0]  kind_r;
  logic [31:0] sval_r;
  logic [1:0]  wr_phase_r; // set once ST_MEM0 has run; gates the load writeback

  // result register
  logic        o_valid_r;
  logic [135:0] o_data_r;

  // memory and register file
  logic [31:0] mem [rv32_pkg::MemWords];
  logic [31:0] rf  [32];
  logic [31:0] mem_q, rf_q;
  logic          mem_we;
  logic [WB-1:0] mem_addr;
  logic [31:0]   mem_wd;
  logic [3:0]    mem_be;
  logic          rf_we;
  logic [4:0]    rf_ra, rf_wa;
  logic [31:0]   rf_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      for (int i = 0; i < 4; i++)
        if (mem_be[i]) mem[mem_addr][8*i +: 8] <= mem_wd[8*i +: 8];
    end
    mem_q <= mem[mem_addr];
  end

  // register file, a write in the same cycle is forwarded to the read
  always_ff @(posedge clk) begin
    if (rf_we) rf[rf_wa] <= rf_wd;
    rf_q <= (rf_ra == 5'd0) ? 32'd0 :
            (rf_we && rf_wa == rf_ra) ? rf_wd : rf[rf_ra];
  end

  // ---- decode of the held instruction ----
  logic [6:0] op, f7;
  logic [4:0] rd, rs2;
  logic [2:0] f3;
  logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
  assign op  = ins_r[6:0];
  assign rd  = ins_r[11:7];
  assign f3  = ins_r[14:12];
  assign rs2 = ins_r[24:20];
  assign f7  = ins_r[31:25];
  assign imm_i = {{20{ins_r[31]}}, ins_r[31:20]};
  assign imm_s = {{20{ins_r[31]}}, ins_r[31:25], ins_r[11:7]};
  assign imm_b = {{20{ins_r[31]}}, ins_r[7], ins_r[30:25], ins_r[11:8], 1'b0};
  assign imm_u = {ins_r[31:12], 12'd0};
  assign imm_j = {{12{ins_r[31]}}, ins_r[19:12], ins_r[20], ins_r[30:21], 1'b0};

  // ALU result for register and immediate ops (b = rf_q for register ops in ST_OPS)
  logic [31:0] alu_b, alu_y;
  logic        alu_wr;
  logic        is_imm;
  assign is_imm = (op == rv32_pkg::OP_IMM);
  assign alu_b  = is_imm ? imm_i : rf_q;

  always_comb begin
    logic [4:0] sh;
    sh = is_imm ? rs2 : rf_q[4:0];
    alu_y  = 32'd0;
    alu_wr = 1'b0;
    unique case (f3)
      3'd0: begin
        if (is_imm || f7 == 7'd0) begin alu_y = a_r + alu_b; alu_wr = 1'b1; end
        else if (f7 == rv32_pkg::F7_ALT) begin alu_y = a_r - alu_b; alu_wr = 1'b1; end
      end
      3'd1: if (f7 == 7'd0) begin alu_y = a_r << sh; alu_wr = 1'b1; end
      3'd2: if (is_imm || f7 == 7'd0) begin
        alu_y = {31'd0, $signed(a_r) < $signed(alu_b)}; alu_wr = 1'b1;
      end
      3'd3: if (is_imm || f7 == 7'd0) begin alu_y = {31'd0, a_r < alu_b}; alu_wr = 1'b1; end
      3'd4: if (is_imm || f7 == 7'd0) begin alu_y = a_r ^ alu_b; alu_wr = 1'b1; end
      3'd5: begin
        if (f7 == 7'd0) begin alu_y = a_r >> sh; alu_wr = 1'b1; end
        else if (f7 == rv32_pkg::F7_ALT) begin
          alu_y = $unsigned($signed(a_r) >>> sh); alu_wr = 1'b1;
        end
      end
      3'd6: if (is_imm || f7 == 7'd0) begin alu_y = a_r | alu_b; alu_wr = 1'b1; end
      3'd7: if (is_imm || f7 == 7'd0) begin alu_y = a_r & alu_b; alu_wr = 1'b1; end
      default: ;
    endcase
  end

  // branch decision
  logic take;
  always_comb begin
    unique case (f3)
      3'd0: take = (a_r == rf_q);
      3'd1: take = (a_r != rf_q);
      3'd4: take = $signed(a_r) < $signed(rf_q);
      3'd5: take = !($signed(a_r) < $signed(rf_q));
      3'd6: take = a_r < rf_q;
      3'd7: take = a_r >= rf_q;
      default: take = 1'b0;
    endcase
  end

  // effective address and its split
  logic [31:0] ea_now;
  assign ea_now = a_r + ((op == rv32_pkg::OP_STORE) ? imm_s : imm_i);
  logic [1:0] boff;
  assign boff = ea_r[1:0];
  logic [63:0] two_words;
  assign two_words = {mem_q, w0_r};
  logic [31:0] ld_raw;
  assign ld_raw = two_words[8*boff +: 32];
  logic [1:0] acc_bytes; // bytes minus one
  assign acc_bytes = (f3[1:0] == 2'd0) ? 2'd0 : (f3[1:0] == 2'd1) ? 2'd1 : 2'd3;

  logic [31:0] ld_val;
  always_comb begin
    unique case (f3)
      3'd0: ld_val = {{24{ld_raw[7]}}, ld_raw[7:0]};
      3'd1: ld_val = {{16{ld_raw[15]}}, ld_raw[15:0]};
      3'd4: ld_val = {24'd0, ld_raw[7:0]};
      3'd5: ld_val = {16'd0, ld_raw[15:0]};
      default: ld_val = ld_raw;
    endcase
  end

  // store data in a 64-bit two-word window, placed by the address computed now
  logic [63:0] st_data;
  logic [7:0]  st_be;
  assign st_data = {32'd0, rf_q} << (8 * ea_now[1:0]);
  assign st_be   = ({4'd0, (acc_bytes == 2'd0) ? 4'b0001 :
                            (acc_bytes == 2'd1) ? 4'b0011 : 4'b1111}) << ea_now[1:0];
  logic [63:0] st_data_r;
  logic [7:0]  st_be_r;

  logic mem_ok;
  assign mem_ok = (pc_r[31:rv32_pkg::MemAddrBits] == '0);
  logic [31:0] ins_word;
  assign ins_word = two_words[8*pc_r[1:0] +: 32];

  logic [31:0] pc4;
  assign pc4 = pc_r + 32'd4;

  // ---- next state ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rv32_pkg::ST_CLEAR:
        if (clr_r == {WB{1'b1}}) state_nxt = rv32_pkg::ST_IDLE;
      rv32_pkg::ST_IDLE:
        if (in_tvalid && in_tready) begin
          if (in_tdata[1:0] == rv32_pkg::ACT_EXECUTE && !halt_r && mem_ok)
            state_nxt = rv32_pkg::ST_FETCH;
          else
            state_nxt = rv32_pkg::ST_REGOUT;
        end
      rv32_pkg::ST_FETCH:  state_nxt = rv32_pkg::ST_MEM1;
      rv32_pkg::ST_MEM1:   state_nxt = rv32_pkg::ST_DECODE;
      rv32_pkg::ST_DECODE:
        state_nxt = (ins_r == 32'd0) ? rv32_pkg::ST_REGOUT : rv32_pkg::ST_OPS;
      rv32_pkg::ST_OPS:
        if ((op == rv32_pkg::OP_LOAD || op == rv32_pkg::OP_STORE) && wr_phase_r != 2'd3)
          state_nxt = rv32_pkg::ST_MEM0;
        else
          state_nxt = rv32_pkg::ST_REGOUT;
      rv32_pkg::ST_MEM0:   state_nxt = rv32_pkg::ST_REGOUT;
      rv32_pkg::ST_REGOUT: state_nxt = rv32_pkg::ST_RESULT;
      rv32_pkg::ST_RESULT:
        if (!o_valid_r || out_tready) state_nxt = rv32_pkg::ST_IDLE;
      default: state_nxt = rv32_pkg::ST_IDLE;
    endcase
  end

  assign in_tready  = (state_r == rv32_pkg::ST_IDLE);
  assign out_tvalid = o_valid_r;
  assign out_tdata  = o_data_r;

  // ---- memory and regfile port control ----
  always_comb begin
    mem_we   = 1'b0;
    mem_addr = pc_r[rv32_pkg::MemAddrBits-1:2];
    mem_wd   = 32'd0;
    mem_be   = 4'd0;
    rf_we    = 1'b0;
    rf_wa    = rd;
    rf_wd    = 32'd0;
    rf_ra    = ridx_r;
    unique case (state_r)
      rv32_pkg::ST_CLEAR: begin
        mem_we = 1'b1; mem_addr = clr_r; mem_be = 4'hF;
        rf_we  = 1'b1; rf_wa = clr_r[4:0];
      end
      rv32_pkg::ST_IDLE: begin
        // byte write goes straight in; otherwise the pc word is read for a fetch
        if (in_tvalid && in_tdata[1:0] == rv32_pkg::ACT_WRITE_BYTE) begin
          mem_we   = 1'b1;
          mem_addr = in_tdata[rv32_pkg::MemAddrBits+1:4];
          mem_be   = 4'b0001 << in_tdata[3:2];
          mem_wd   = {4{in_tdata[25:18]}};
        end
      end
      rv32_pkg::ST_FETCH: mem_addr = pc_r[rv32_pkg::MemAddrBits-1:2] + 1'b1;
      rv32_pkg::ST_MEM1:
        rf_ra = (ins_word == rv32_pkg::INS_ECALL) ? rv32_pkg::REG_SVC : ins_word[19:15];
      rv32_pkg::ST_DECODE:
        rf_ra = (ins_r == rv32_pkg::INS_ECALL) ? rv32_pkg::REG_ARG0 : rs2;
      rv32_pkg::ST_OPS: begin
        mem_addr = ea_now[rv32_pkg::MemAddrBits-1:2];
        if (op == rv32_pkg::OP_STORE && (f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd2)) begin
          mem_we = 1'b1;
          mem_wd = st_data[31:0];
          mem_be = st_be[3:0];
        end
        if (alu_wr && (op == rv32_pkg::OP_IMM || op == rv32_pkg::OP_REG)) begin
          rf_we = rd != 5'd0; rf_wd = alu_y;
        end
        unique case (op)
          rv32_pkg::OP_AUIPC: begin rf_we = rd != 5'd0; rf_wd = pc_r + imm_u; end
          rv32_pkg::OP_LUI:   begin rf_we = rd != 5'd0; rf_wd = imm_u; end
          rv32_pkg::OP_JAL:   begin rf_we = rd != 5'd0; rf_wd = pc4; end
          rv32_pkg::OP_JALR:  if (f3 == 3'd0) begin rf_we = rd != 5'd0; rf_wd = pc4; end
          default: ;
        endcase
        // console read: a_r holds a7
        if (ins_r == rv32_pkg::INS_ECALL && a_r == rv32_pkg::SVC_READ) begin
          rf_we = 1'b1; rf_wa = rv32_pkg::REG_ARG0; rf_wd = cons_r;
        end
      end
      rv32_pkg::ST_MEM0: begin
        mem_addr = ea_r[rv32_pkg::MemAddrBits-1:2] + 1'b1;
        if (op == rv32_pkg::OP_STORE && (f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd2)) begin
          mem_we = st_be_r[7:4] != 4'd0;
          mem_wd = st_data_r[63:32];
          mem_be = st_be_r[7:4];
        end
      end
      rv32_pkg::ST_REGOUT: begin
        if (op == rv32_pkg::OP_LOAD && act_r == rv32_pkg::ACT_EXECUTE && wr_phase_r == 2'd1
            && (f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd2 || f3 == 3'd4 || f3 == 3'd5)) begin
          rf_we = rd != 5'd0; rf_wd = ld_val;
        end
      end
      default: ;
    endcase
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= rv32_pkg::ST_CLEAR;
      clr_r      <= '0;
      pc_r       <= 32'd0;
      cnt_r      <= 32'd0;
      halt_r     <= 1'b0;
      o_valid_r  <= 1'b0;
      wr_phase_r <= 2'd0;
      kind_r     <= rv32_pkg::SYS_NONE;
      act_r      <= rv32_pkg::ACT_READ_REG;
    end else begin
      state_r <= state_nxt;
      if (state_r == rv32_pkg::ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (cfg_we) begin
        pc_r <= cfg_wdata;
      end
      // result valid: loaded in ST_RESULT, dropped once taken
      if (state_r == rv32_pkg::ST_RESULT) o_valid_r <= 1'b1;
      else if (out_tready) o_valid_r <= 1'b0;
      unique case (state_r)
        rv32_pkg::ST_IDLE: if (in_tvalid) begin
          act_r      <= in_tdata[1:0];
          ridx_r     <= in_tdata[30:26];
          cons_r     <= in_tdata[62:31];
          kind_r     <= rv32_pkg::SYS_NONE;
          sval_r     <= 32'd0;
          wr_phase_r <= 2'd0;
          ins_r      <= 32'd0;
          if (in_tdata[1:0] == rv32_pkg::ACT_EXECUTE && (halt_r || !mem_ok))
            halt_r <= 1'b1;
        end
        rv32_pkg::ST_FETCH: w0_r <= mem_q;
        rv32_pkg::ST_MEM1: begin
          ins_r <= ins_word;
          if (ins_word == 32'd0) halt_r <= 1'b1;
        end
        rv32_pkg::ST_DECODE: begin
          // rs1, or a7 for an ecall
          a_r <= rf_q;
        end
        rv32_pkg::ST_OPS: begin
          ea_r      <= ea_now;
          st_data_r <= st_data;
          st_be_r   <= st_be;
          if (ins_r == rv32_pkg::INS_ECALL) begin
            // ecall: rf_q is a0, a_r is a7
            if (a_r == rv32_pkg::SVC_PRINT) begin
              kind_r <= rv32_pkg::SYS_PRINT; sval_r <= rf_q;
            end else if (a_r == rv32_pkg::SVC_EXIT) begin
              kind_r <= rv32_pkg::SYS_EXIT; halt_r <= 1'b1;
            end else if (a_r == rv32_pkg::SVC_READ) begin
              kind_r <= rv32_pkg::SYS_READ;
            end else begin
              kind_r <= rv32_pkg::SYS_UNIMPL; sval_r <= a_r;
            end
          end
          if (ins_r == rv32_pkg::INS_EBREAK) begin
            kind_r <= rv32_pkg::SYS_BREAK; halt_r <= 1'b1;
          end
          cnt_r <= cnt_r + 32'd1;
          pc_r  <= pc4;
          unique case (op)
            rv32_pkg::OP_BRANCH: if (take) pc_r <= pc_r + imm_b;
            rv32_pkg::OP_JAL:    pc_r <= pc_r + imm_j;
            rv32_pkg::OP_JALR:   if (f3 == 3'd0) pc_r <= (a_r + imm_i) & ~32'd1;
            default: ;
          endcase
        end
        rv32_pkg::ST_MEM0: begin
          w0_r       <= mem_q;
          wr_phase_r <= 2'd1;
        end
        rv32_pkg::ST_RESULT: if (!o_valid_r || out_tready) begin
          o_data_r  <= {4'd0, sval_r, kind_r, rf_q, cnt_r, pc_r, halt_r};
        end
        default: ;
      endcase
    end
  end

endmodule
